// File: src/first_fit_heap_allocator_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the first-fit heap allocator.
// Each macro expects signals named clk and rst_n in the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFHA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap allocator check failed");

// Next-cycle implication, checked outside reset.
`define FFHA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap allocator check failed");

`endif

// File: src/ffha_pkg.sv
// ---------------------------------------------------------------------------
// ffha_pkg
// Types and constants of the first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES = 4096;
    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int ADDR_W     = $clog2(HEAP_WORDS);
    localparam int PTR_W      = ADDR_W + 1;
    localparam int SIZE_W     = ADDR_W;
    localparam int HDR_WORDS  = 2;

    typedef enum logic [1:0] {
        MARK_NONE = 2'd0,
        MARK_FREE = 2'd1,
        MARK_USED = 2'd2,
        MARK_BAD  = 2'd3
    } mark_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_ZERO    = 2'd1,
        STAT_NO_FIT  = 2'd2,
        STAT_IGNORED = 2'd3
    } status_t;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Header entry: payload size in 4-byte words and the mark.
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        mark_t             mark;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_RD,
        ST_A_EV,
        ST_A_SPL,
        ST_R_EV,
        ST_W_RD,
        ST_W_EV,
        ST_W_NX,
        ST_W_WB,
        ST_DONE
    } state_t;

endpackage

// File: src/ffha_if.sv
// ---------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels carrying allocator requests and responses.
// ---------------------------------------------------------------------------
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [12:0] request_bytes;
    logic [11:0] release_offset;

    modport source (output valid, kind, request_bytes, release_offset, input ready);
    modport sink   (input valid, kind, request_bytes, release_offset, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] granted_offset;
    logic [12:0] free_bytes;

    modport source (output valid, status, granted_offset, free_bytes, input ready);
    modport sink   (input valid, status, granted_offset, free_bytes, output ready);
endinterface

// File: src/first_fit_heap_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a 4 KiB heap with merging of free neighbors.
// ---------------------------------------------------------------------------
// Requests arrive on req (kind, request_bytes, release_offset) and each one
// produces exactly one beat on rsp (status, granted_offset, free_bytes).
// All headers live in one 1024-entry synchronous RAM, one entry per heap
// word, read through a registered port. An allocate walks the block chain
// from the start, with a read state and an evaluate state per block it
// visits and a split state when it splits a block. A release at a valid
// offset reads its header and checks its mark. Every request then walks
// the whole chain once more to sum the free payload (and, after a release,
// to merge free neighbors).
// One request is in work at a time; req.ready is high only while idle.
// A finished response sits in the output register until rsp.ready takes it;
// the next request may be accepted meanwhile but cannot finish before then.
// After reset the RAM is cleared entry by entry, during which req.ready is low.
// ---------------------------------------------------------------------------
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator (
    input  logic       clk,
    input  logic       rst_n,
    ffha_req_if.sink   req,
    ffha_rsp_if.source rsp
);
    import ffha_pkg::*;

    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(HEAP_WORDS);

    entry_t              mem [HEAP_WORDS];
    entry_t              rd_reg;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    entry_t              mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [PTR_W-1:0]    cur_reg, cur_next;
    logic [PTR_W-1:0]    nb_reg, nb_next;
    logic [PTR_W-1:0]    sz_reg, sz_next;
    logic [SIZE_W-1:0]   bs_reg, bs_next;
    logic [PTR_W-1:0]    sum_reg, sum_next;
    logic                merge_reg, merge_next;
    status_t             stat_reg, stat_next;
    logic [11:0]         gr_reg, gr_next;

    logic                out_valid_reg, out_valid_next;
    status_t             out_stat_reg, out_stat_next;
    logic [11:0]         out_gr_reg, out_gr_next;
    logic [12:0]         out_free_reg, out_free_next;

    logic [PTR_W:0]      nxt_rd, nxt_bs;
    logic [PTR_W:0]      fit_need;
    logic [PTR_W-1:0]    rd_end, bs_end;
    logic [SIZE_W:0]     grown;
    logic                rel_bad;

    // Header RAM: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        nb_reg       <= nb_next;
        sz_reg       <= sz_next;
        bs_reg       <= bs_next;
        sum_reg      <= sum_next;
        merge_reg    <= merge_next;
        stat_reg     <= stat_next;
        gr_reg       <= gr_next;
        out_stat_reg <= out_stat_next;
        out_gr_reg   <= out_gr_next;
        out_free_reg <= out_free_next;
    end

    // Next-block pointers, saturated to the chain end.
    assign nxt_rd   = {1'b0, cur_reg} + (PTR_W+1)'(HDR_WORDS) + (PTR_W+1)'(rd_reg.size);
    assign nxt_bs   = {1'b0, cur_reg} + (PTR_W+1)'(HDR_WORDS) + (PTR_W+1)'(bs_reg);
    assign rd_end   = (nxt_rd >= (PTR_W+1)'(HEAP_WORDS)) ? PTR_END : nxt_rd[PTR_W-1:0];
    assign bs_end   = (nxt_bs >= (PTR_W+1)'(HEAP_WORDS)) ? PTR_END : nxt_bs[PTR_W-1:0];
    assign fit_need = {1'b0, sz_reg} + (PTR_W+1)'(HDR_WORDS);
    assign grown    = (SIZE_W+1)'(bs_reg) + (SIZE_W+1)'(rd_reg.size)
                    + (SIZE_W+1)'(HDR_WORDS);
    assign rel_bad  = (req.release_offset < 12'd8)
                   || (req.release_offset > 12'(HEAP_BYTES - 8))
                   || (req.release_offset[1:0] != 2'b00);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        nb_next        = nb_reg;
        sz_next        = sz_reg;
        bs_next        = bs_reg;
        sum_next       = sum_reg;
        merge_next     = merge_reg;
        stat_next      = stat_reg;
        gr_next        = gr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_stat_next  = out_stat_reg;
        out_gr_next    = out_gr_reg;
        out_free_next  = out_free_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg[ADDR_W-1:0];
        mem_wdata      = '{size: '0, mark: MARK_NONE};
        mem_re         = 1'b0;
        mem_raddr      = cur_reg[ADDR_W-1:0];
        req.ready      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == '0)
                begin
                    mem_wdata = '{size: SIZE_W'(HEAP_WORDS - HDR_WORDS), mark: MARK_FREE};
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(HEAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                req.ready  = 1'b1;
                cur_next   = '0;
                sum_next   = '0;
                merge_next = 1'b0;
                stat_next  = STAT_OK;
                gr_next    = '0;
                // Requests of a whole heap or more can never fit, so they are
                // clamped to a word count larger than any block.
                sz_next    = req.request_bytes[12]
                           ? PTR_END
                           : PTR_W'(({1'b0, req.request_bytes[11:0]} + 13'd3) >> 2);
                if (req.valid)
                begin
                    if (req.kind == KIND_ALLOC)
                    begin
                        if (req.request_bytes == '0)
                        begin
                            stat_next  = STAT_ZERO;
                            state_next = ST_W_RD;
                        end
                        else
                        begin
                            state_next = ST_A_RD;
                        end
                    end
                    else if (rel_bad)
                    begin
                        stat_next  = STAT_IGNORED;
                        state_next = ST_W_RD;
                    end
                    else
                    begin
                        // Header word sits two words below the payload.
                        mem_re     = 1'b1;
                        mem_raddr  = req.release_offset[11:2] - ADDR_W'(HDR_WORDS);
                        nb_next    = {1'b0, mem_raddr};
                        state_next = ST_R_EV;
                    end
                end
            end

            ST_A_RD:
            begin
                if (cur_reg >= PTR_END)
                begin
                    stat_next  = STAT_NO_FIT;
                    cur_next   = '0;
                    state_next = ST_W_RD;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_A_EV;
                end
            end

            ST_A_EV:
            begin
                if (rd_reg.mark == MARK_FREE && PTR_W'(rd_reg.size) == sz_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = '{size: rd_reg.size, mark: MARK_USED};
                    gr_next    = 12'({cur_reg, 2'b00} + (PTR_W+2)'(8));
                    cur_next   = '0;
                    state_next = ST_W_RD;
                end
                else if (rd_reg.mark == MARK_FREE
                         && (PTR_W+1)'(rd_reg.size) >= fit_need)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = '{size: sz_reg[SIZE_W-1:0], mark: MARK_USED};
                    bs_next    = rd_reg.size - sz_reg[SIZE_W-1:0] - SIZE_W'(HDR_WORDS);
                    gr_next    = 12'({cur_reg, 2'b00} + (PTR_W+2)'(8));
                    state_next = ST_A_SPL;
                end
                else
                begin
                    cur_next   = rd_end;
                    state_next = ST_A_RD;
                end
            end

            ST_A_SPL:
            begin
                // Remainder of the split becomes a new free block.
                mem_we     = 1'b1;
                mem_waddr  = ADDR_W'(cur_reg + sz_reg + PTR_W'(HDR_WORDS));
                mem_wdata  = '{size: bs_reg, mark: MARK_FREE};
                cur_next   = '0;
                state_next = ST_W_RD;
            end

            ST_R_EV:
            begin
                if (rd_reg.mark == MARK_USED)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = nb_reg[ADDR_W-1:0];
                    mem_wdata  = '{size: rd_reg.size, mark: MARK_FREE};
                    merge_next = 1'b1;
                end
                else
                begin
                    stat_next = STAT_IGNORED;
                end
                cur_next   = '0;
                state_next = ST_W_RD;
            end

            ST_W_RD:
            begin
                if (cur_reg >= PTR_END)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_W_EV;
                end
            end

            ST_W_EV:
            begin
                bs_next = rd_reg.size;
                if (rd_reg.mark == MARK_FREE && merge_reg && rd_end < PTR_END)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = rd_end[ADDR_W-1:0];
                    nb_next    = rd_end;
                    state_next = ST_W_NX;
                end
                else
                begin
                    if (rd_reg.mark == MARK_FREE)
                    begin
                        sum_next = sum_reg + PTR_W'(rd_reg.size);
                    end
                    cur_next   = rd_end;
                    state_next = ST_W_RD;
                end
            end

            ST_W_NX:
            begin
                if (rd_reg.mark == MARK_FREE)
                begin
                    // Absorb the neighbor: clear its header, grow this one next.
                    mem_we     = 1'b1;
                    mem_waddr  = nb_reg[ADDR_W-1:0];
                    bs_next    = grown[SIZE_W-1:0];
                    state_next = ST_W_WB;
                end
                else
                begin
                    sum_next   = sum_reg + PTR_W'(bs_reg);
                    cur_next   = nb_reg;
                    state_next = ST_W_RD;
                end
            end

            ST_W_WB:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{size: bs_reg, mark: MARK_FREE};
                if (bs_end < PTR_END)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = bs_end[ADDR_W-1:0];
                    nb_next    = bs_end;
                    state_next = ST_W_NX;
                end
                else
                begin
                    sum_next   = sum_reg + PTR_W'(bs_reg);
                    cur_next   = PTR_END;
                    state_next = ST_W_RD;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_gr_next    = gr_reg;
                    out_free_next  = 13'({sum_reg, 2'b00});
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_stat_reg;
    assign rsp.granted_offset = out_gr_reg;
    assign rsp.free_bytes     = out_free_reg;

    `FFHA_ASSERT_NOW(a_grant_ok, rsp.valid && rsp.granted_offset != 12'd0, rsp.status == STAT_OK)
    `FFHA_ASSERT_NOW(a_grant_align, rsp.valid, rsp.granted_offset[1:0] == 2'b00)
    `FFHA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, state_reg != ST_IDLE)
    `FFHA_ASSERT_NOW(a_sum_bound, state_reg == ST_DONE, sum_reg <= PTR_W'(HEAP_WORDS - HDR_WORDS))

endmodule
